### rtl/core/pidd_pkg.sv
// ----------------------------------------------------------------------------
// pidd_pkg: shared types and constants for the deadband PID controller
// Widths of the datapath, register map codes and stage payload structs.
// ----------------------------------------------------------------------------
package pidd_pkg;

	// Sample and gain format
	localparam int SAMPLE_WIDTH   = 16;
	localparam int GAIN_FRAC_BITS = 8;

	// Register field widths
	localparam int GAIN_W        = 16;
	localparam int DRIVE_LIMIT_W = 15;
	localparam int SUM_LIMIT_W   = 24;
	localparam int DEAD_ZONE_W   = 16;
	localparam int FF_W          = 16;

	// Output and state widths
	localparam int DRIVE_W = 16;
	localparam int SUM_W   = SUM_LIMIT_W + 1;

	// Datapath widths
	localparam int ERR_W   = SAMPLE_WIDTH + 1;
	localparam int CMP_W   = (ERR_W > DEAD_ZONE_W) ? ERR_W : DEAD_ZONE_W;
	localparam int ADD_W   = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
	localparam int DERIV_W = ERR_W + 1;
	localparam int P_W     = GAIN_W + ERR_W;
	localparam int I_W     = GAIN_W + SUM_W;
	localparam int D_W     = GAIN_W + DERIV_W;
	localparam int PI_MAX  = (P_W > I_W) ? P_W : I_W;
	localparam int ACC_W   = ((PI_MAX > D_W) ? PI_MAX : D_W) + 2;
	localparam int DRV_W   = ((ACC_W > FF_W) ? ACC_W : FF_W) + 1;

	// Configuration port
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;
	localparam int APB_ADDR_W = REG_IDX_W + 2;

	// Reset values
	localparam logic [DRIVE_LIMIT_W-1:0] DRIVE_LIMIT_RST = '1;
	localparam logic [SUM_LIMIT_W-1:0]   SUM_LIMIT_RST   = '1;

	// Operation codes of an input item
	localparam logic OP_STEP  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_DRIVE_LIMIT,
		REG_SUM_LIMIT,
		REG_DEAD_ZONE,
		REG_FEED_FORWARD
	} reg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0]  gain_p;
		logic signed [GAIN_W-1:0]  gain_i;
		logic signed [GAIN_W-1:0]  gain_d;
		logic [DRIVE_LIMIT_W-1:0]  drive_limit;
		logic [SUM_LIMIT_W-1:0]    sum_limit;
		logic [DEAD_ZONE_W-1:0]    dead_zone;
		logic signed [FF_W-1:0]    feed_forward;
	} cfg_t;

	// Error terms of one item
	typedef struct packed {
		logic                      op;
		logic signed [ERR_W-1:0]   err;
		logic signed [SUM_W-1:0]   sum;
		logic signed [DERIV_W-1:0] deriv;
	} err_item_t;

	// Gained terms of one item
	typedef struct packed {
		logic                  op;
		logic signed [P_W-1:0] prod_p;
		logic signed [I_W-1:0] prod_i;
		logic signed [D_W-1:0] prod_d;
	} prod_item_t;

endpackage

### rtl/core/pidd_cfg_regs.sv
// ----------------------------------------------------------------------------
// pidd_cfg_regs: configuration register file
// APB-style write and read of the gains, limits, deadband and feedforward.
// ----------------------------------------------------------------------------
module pidd_cfg_regs
	import pidd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p       <= '0;
			cfg_q.gain_i       <= '0;
			cfg_q.gain_d       <= '0;
			cfg_q.drive_limit  <= DRIVE_LIMIT_RST;
			cfg_q.sum_limit    <= SUM_LIMIT_RST;
			cfg_q.dead_zone    <= '0;
			cfg_q.feed_forward <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN_P:       cfg_q.gain_p       <= pwdata[GAIN_W-1:0];
				REG_GAIN_I:       cfg_q.gain_i       <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:       cfg_q.gain_d       <= pwdata[GAIN_W-1:0];
				REG_DRIVE_LIMIT:  cfg_q.drive_limit  <= pwdata[DRIVE_LIMIT_W-1:0];
				REG_SUM_LIMIT:    cfg_q.sum_limit    <= pwdata[SUM_LIMIT_W-1:0];
				REG_DEAD_ZONE:    cfg_q.dead_zone    <= pwdata[DEAD_ZONE_W-1:0];
				REG_FEED_FORWARD: cfg_q.feed_forward <= pwdata[FF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GAIN_P:       prdata = APB_DATA_W'($unsigned(cfg_q.gain_p));
			REG_GAIN_I:       prdata = APB_DATA_W'($unsigned(cfg_q.gain_i));
			REG_GAIN_D:       prdata = APB_DATA_W'($unsigned(cfg_q.gain_d));
			REG_DRIVE_LIMIT:  prdata = APB_DATA_W'(cfg_q.drive_limit);
			REG_SUM_LIMIT:    prdata = APB_DATA_W'(cfg_q.sum_limit);
			REG_DEAD_ZONE:    prdata = APB_DATA_W'(cfg_q.dead_zone);
			REG_FEED_FORWARD: prdata = APB_DATA_W'($unsigned(cfg_q.feed_forward));
			default:          prdata = '0;
		endcase
	end

endmodule

### rtl/core/pidd_err_stage.sv
// ----------------------------------------------------------------------------
// pidd_err_stage: input register and error update
// Error, deadband, clamped error sum and derivative; owns the stored state.
// ----------------------------------------------------------------------------
module pidd_err_stage
	import pidd_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           op,
	input  logic signed [SAMPLE_WIDTH-1:0] target,
	input  logic signed [SAMPLE_WIDTH-1:0] measured,
	output logic                           dn_valid,
	input  logic                           dn_ready,
	output err_item_t                      dn_item
);

	logic                           v_s1;
	logic                           op_s1;
	logic signed [SAMPLE_WIDTH-1:0] target_s1;
	logic signed [SAMPLE_WIDTH-1:0] measured_s1;
	logic                           v_s2;
	err_item_t                      item_s2;

	logic signed [SUM_W-1:0]        error_sum_q;
	logic signed [ERR_W-1:0]        prev_err_q;

	logic                           ld_s1;
	logic                           ld_s2;
	logic                           fire_s2;

	logic signed [ERR_W-1:0]        err_raw;
	logic [ERR_W-1:0]               err_mag;
	logic                           in_dz;
	logic signed [ERR_W-1:0]        err_dz;
	logic signed [ADD_W-1:0]        sum_raw;
	logic signed [ADD_W-1:0]        sum_lim;
	logic signed [ADD_W-1:0]        sum_clip;
	logic signed [DERIV_W-1:0]      deriv;
	err_item_t                      item_nxt;

	assign ld_s2    = !v_s2 || dn_ready;
	assign ld_s1    = !v_s1 || ld_s2;
	assign fire_s2  = v_s1 && ld_s2;
	assign in_ready = ld_s1;
	assign dn_valid = v_s2;
	assign dn_item  = item_s2;

	always_comb begin
		err_raw = ERR_W'(target_s1) - ERR_W'(measured_s1);
		err_mag = err_raw[ERR_W-1] ? $unsigned(-err_raw) : $unsigned(err_raw);
		in_dz   = CMP_W'(err_mag) < CMP_W'(cfg.dead_zone);
		err_dz  = in_dz ? '0 : err_raw;

		// anti-windup: sum saturates at +/- sum_limit
		sum_raw = ADD_W'(error_sum_q) + ADD_W'(err_dz);
		sum_lim = ADD_W'($signed({1'b0, cfg.sum_limit}));
		if (sum_raw > sum_lim)
			sum_clip = sum_lim;
		else if (sum_raw < -sum_lim)
			sum_clip = -sum_lim;
		else
			sum_clip = sum_raw;

		deriv = DERIV_W'(err_dz) - DERIV_W'(prev_err_q);

		item_nxt.op    = op_s1;
		item_nxt.err   = err_dz;
		item_nxt.sum   = SUM_W'(sum_clip);
		item_nxt.deriv = deriv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			error_sum_q <= '0;
			prev_err_q  <= '0;
		end else begin
			if (ld_s1)
				v_s1 <= in_valid;
			if (ld_s2)
				v_s2 <= v_s1;
			if (fire_s2) begin
				if (op_s1 == OP_CLEAR) begin
					error_sum_q <= '0;
					prev_err_q  <= '0;
				end else begin
					error_sum_q <= SUM_W'(sum_clip);
					prev_err_q  <= err_dz;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1 && in_valid) begin
			op_s1       <= op;
			target_s1   <= target;
			measured_s1 <= measured;
		end
		if (fire_s2)
			item_s2 <= item_nxt;
	end

endmodule

### rtl/core/pidd_mul_stage.sv
// ----------------------------------------------------------------------------
// pidd_mul_stage: gain multipliers
// Three parallel signed products of the error terms and the gains.
// ----------------------------------------------------------------------------
module pidd_mul_stage
	import pidd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       up_valid,
	output logic       up_ready,
	input  err_item_t  up_item,
	output logic       dn_valid,
	input  logic       dn_ready,
	output prod_item_t dn_item
);

	logic       v_s3;
	prod_item_t item_s3;
	prod_item_t item_nxt;
	logic       ld_s3;

	assign ld_s3    = !v_s3 || dn_ready;
	assign up_ready = ld_s3;
	assign dn_valid = v_s3;
	assign dn_item  = item_s3;

	always_comb begin
		item_nxt.op     = up_item.op;
		item_nxt.prod_p = P_W'(cfg.gain_p) * P_W'(up_item.err);
		item_nxt.prod_i = I_W'(cfg.gain_i) * I_W'(up_item.sum);
		item_nxt.prod_d = D_W'(cfg.gain_d) * D_W'(up_item.deriv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (ld_s3)
			v_s3 <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (ld_s3 && up_valid)
			item_s3 <= item_nxt;
	end

endmodule

### rtl/core/pidd_out_stage.sv
// ----------------------------------------------------------------------------
// pidd_out_stage: term sum, scaling, feedforward and drive clamp
// Result register holding the drive and the clamp flag.
// ----------------------------------------------------------------------------
module pidd_out_stage
	import pidd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      up_valid,
	output logic                      up_ready,
	input  prod_item_t                up_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [DRIVE_W-1:0] drive,
	output logic                      clamped
);

	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic                      clamped_q;
	logic                      ld_out;

	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   acc_sh;
	logic signed [DRV_W-1:0]   drv;
	logic signed [DRV_W-1:0]   drv_lim;
	logic signed [DRV_W-1:0]   drv_clip;
	logic                      clip;

	assign ld_out    = !out_valid_q || out_ready;
	assign up_ready  = ld_out;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign clamped   = clamped_q;

	always_comb begin
		acc     = ACC_W'(up_item.prod_p) + ACC_W'(up_item.prod_i) + ACC_W'(up_item.prod_d);
		// arithmetic shift floors toward minus infinity
		acc_sh  = acc >>> GAIN_FRAC_BITS;
		drv     = DRV_W'(acc_sh) + DRV_W'(cfg.feed_forward);
		drv_lim = DRV_W'($signed({1'b0, cfg.drive_limit}));
		if (drv > drv_lim) begin
			drv_clip = drv_lim;
			clip     = 1'b1;
		end else if (drv < -drv_lim) begin
			drv_clip = -drv_lim;
			clip     = 1'b1;
		end else begin
			drv_clip = drv;
			clip     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ld_out)
			out_valid_q <= up_valid;
	end

	always_ff @(posedge clk) begin
		if (ld_out && up_valid) begin
			if (up_item.op == OP_CLEAR) begin
				drive_q   <= '0;
				clamped_q <= 1'b0;
			end else begin
				drive_q   <= DRIVE_W'(drv_clip);
				clamped_q <= clip;
			end
		end
	end

endmodule

### rtl/core/pid_controller_deadband.sv
// ----------------------------------------------------------------------------
// pid_controller_deadband: positional PID step with deadband and anti-windup
// Fixed-point PID with error deadband, clamped error sum, feedforward and
// clamped drive output with a clamp flag. APB-style configuration.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid/in_ready   | op, target, measured
//  output   | out_valid/out_ready | drive, clamped
//  config   | psel/penable/pready | pwrite, paddr, pwdata, prdata
//
// One item per clock sustained while out_ready is high; each item passes from
// acceptance to a valid result through the input register, error stage,
// multiplier stage and result register. The error sum and last error update
// in the error stage as each item moves on, so items follow back to back.
// Reset clears the stored error state and loads the register reset values.
// A stalled output holds each stage only while the stage after it is full.
// ----------------------------------------------------------------------------
module pid_controller_deadband
	import pidd_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,

	// input items
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           op,
	input  logic signed [SAMPLE_WIDTH-1:0] target,
	input  logic signed [SAMPLE_WIDTH-1:0] measured,

	// result items
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [DRIVE_W-1:0]      drive,
	output logic                           clamped,

	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [APB_ADDR_W-1:0]          paddr,
	input  logic [APB_DATA_W-1:0]          pwdata,
	output logic [APB_DATA_W-1:0]          prdata,
	output logic                           pready
);

	cfg_t       cfg;

	// error stage -> multiplier stage
	logic       err_valid;
	logic       err_ready;
	err_item_t  err_item;

	// multiplier stage -> result stage
	logic       prod_valid;
	logic       prod_ready;
	prod_item_t prod_item;

	pidd_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stored state (error sum, last error) lives here and updates as each
	// item leaves the input register.
	pidd_err_stage u_err_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.target   (target),
		.measured (measured),
		.dn_valid (err_valid),
		.dn_ready (err_ready),
		.dn_item  (err_item)
	);

	// P, I and D products in parallel.
	pidd_mul_stage u_mul_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (err_valid),
		.up_ready (err_ready),
		.up_item  (err_item),
		.dn_valid (prod_valid),
		.dn_ready (prod_ready),
		.dn_item  (prod_item)
	);

	// Sum, scale, feedforward, clamp; a clear item yields a zero drive.
	pidd_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.up_valid  (prod_valid),
		.up_ready  (prod_ready),
		.up_item   (prod_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive),
		.clamped   (clamped)
	);

endmodule
